// File: hdl/lru_key_value_cache_macros.svh
// assertion macros used by the cache rtl in lkv_store
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define LKV_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/lkv_pkg.sv
// types and constants of the lru key-value cache
`timescale 1ns / 1ps
package lkv_pkg;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0]          CAP_RESET  = 5'd16;
	localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_SET = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                      command;
		logic signed [KEY_W-1:0]   key;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic fire;
		req_t req;
	} op_t;

endpackage

// File: hdl/lru_key_value_cache.sv
// top level of the fully associative lru key-value cache
//
//   port group  dir  handshake            payload
//   in_*        in   in_valid / in_stall   req_t: command, key, value
//   out_*       out  out_valid / out_stall rsp_t: hit, read_value (one per get)
//   cfg_*       in   cfg_valid / cfg_ready capacity_in_use, 5 bits
//
// one item per cycle unless a stalled result holds back a get; a get result is valid after the
// input register (on the transfer edge), then key match and rank update into the result register
// reset clears all valid marks and occupancy at once, capacity returns to 16
// a stalled result holds back the next get and all behind it; sets ahead of that get keep flowing
// cfg_ready is always high
`timescale 1ns / 1ps
module lru_key_value_cache
	import lkv_pkg::*;
#(
	parameter int ENTRIES    = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output rsp_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	logic [CAP_W-1:0] capacity_q;
	op_t              op;
	rsp_t             rsp;
	logic             out_busy;
	logic             load;

	assign cfg_ready = 1'b1;
	assign load      = op.fire && op.req.command == CMD_GET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	lkv_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_busy (out_busy),
		.op       (op)
	);

	lkv_store #(
		.ENTRIES    (ENTRIES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.op       (op),
		.rsp      (rsp)
	);

	lkv_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.rsp       (rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.out_busy  (out_busy)
	);

endmodule

// File: hdl/lkv_in_reg.sv
// input register stage with stall generation
`timescale 1ns / 1ps
module lkv_in_reg
	import lkv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	input  logic out_busy,
	output op_t  op
);

	logic valid_s1;
	req_t req_s1;
	logic advance;
	logic accept;

	assign advance  = valid_s1 && (req_s1.command == CMD_SET || !out_busy);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign op.fire = advance;
	assign op.req  = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_data;
		end
	end

endmodule

// File: hdl/lkv_store.sv
// entry array with parallel key match and recency ranks
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"
module lkv_store
	import lkv_pkg::*;
#(
	parameter int ENTRIES    = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CAP_W-1:0] capacity,
	input  op_t              op,
	output rsp_t             rsp
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam int EXT_W  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

	logic [ENTRIES-1:0]          valid_q;
	logic signed [KEY_W-1:0]     key_q   [ENTRIES];
	logic [DATA_WIDTH-1:0]       value_q [ENTRIES];
	logic [RANK_W-1:0]           rank_q  [ENTRIES];
	logic [OCC_W-1:0]            occ_q;

	logic [ENTRIES-1:0]    match;
	logic [ENTRIES-1:0]    victim;
	logic [ENTRIES-1:0]    evict;
	logic [ENTRIES-1:0]    valid_after;
	logic [ENTRIES-1:0]    free_oh;
	logic                  hit;
	logic [RANK_W-1:0]     hit_rank;
	logic [DATA_WIDTH-1:0] hit_value;
	logic [EXT_W-1:0]      hit_value_ext;
	logic [RANK_W-1:0]     oldest_rank;
	logic [CMP_W-1:0]      cap_ext;
	logic [CMP_W-1:0]      limit;
	logic                  full;
	logic                  do_insert;
	logic [DATA_WIDTH-1:0] new_value;

	assign cap_ext = CMP_W'(capacity);
	assign limit   = (cap_ext == '0) ? CMP_W'(1) :
	                 (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
	assign full    = CMP_W'(occ_q) >= limit;

	assign oldest_rank = RANK_W'(occ_q - OCC_W'(1));
	assign new_value   = DATA_WIDTH'($unsigned(op.req.value));

	always_comb begin
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == op.req.key);
			victim[i] = valid_q[i] && (rank_q[i] == oldest_rank);
			if (match[i]) begin
				hit_rank  = hit_rank | rank_q[i];
				hit_value = hit_value | value_q[i];
			end
		end
	end

	assign hit         = |match;
	assign evict       = full ? victim : '0;
	assign valid_after = valid_q & ~evict;
	// lowest clear bit of the surviving valid vector
	assign free_oh     = ~valid_after & (valid_after + ENTRIES'(1));
	assign do_insert   = op.fire && !hit && op.req.command == CMD_SET;

	assign hit_value_ext  = EXT_W'(hit_value);
	assign rsp.hit        = hit;
	assign rsp.read_value = hit ? hit_value_ext[VALUE_W-1:0] : MISS_VALUE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (do_insert) begin
			valid_q <= valid_after | free_oh;
			if (!full) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (op.fire && hit) begin
				if (valid_q[i] && rank_q[i] < hit_rank) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
				if (match[i]) begin
					rank_q[i] <= '0;
					if (op.req.command == CMD_SET) begin
						value_q[i] <= new_value;
					end
				end
			end else if (do_insert) begin
				if (free_oh[i]) begin
					key_q[i]   <= op.req.key;
					value_q[i] <= new_value;
					rank_q[i]  <= '0;
				end else if (valid_after[i]) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
		end
	end

	`LKV_ASSERT_ALWAYS(a_key_unique, $onehot0(match), "more than one entry matches the key")
	`LKV_ASSERT_ALWAYS(a_one_victim, !(do_insert && full) || $onehot(victim), "no single lru victim")
	`LKV_ASSERT_ALWAYS(a_occ_count, occ_q == $countones(valid_q), "occupancy out of step with valid marks")
	`LKV_ASSERT_NEXT(a_insert_valid, do_insert, |valid_q, "insert left no valid entry")

endmodule

// File: hdl/lkv_out_reg.sv
// result register toward the output channel
`timescale 1ns / 1ps
module lkv_out_reg
	import lkv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  rsp_t rsp,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data,
	output logic out_busy
);

	logic out_valid_q;
	rsp_t out_data_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_busy  = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= rsp;
		end
	end

endmodule

// File: test/lru_key_value_cache_tb.sv
// testbench for the lru key-value cache: directed and random gets and sets checked against a built-in lru predictor
`timescale 1ns / 1ps
module lru_key_value_cache_tb;
	import lkv_pkg::*;

	localparam int ENTRIES        = 16;
	localparam int SETTLE_CYCLES  = 4;
	localparam int HOLD_CYCLES    = 80;
	localparam int PRESSURE_ITEMS = 40;
	localparam int PHASE_ITEMS    = 100;
	localparam int WATCHDOG_LIMIT = 2000;

	class cache_scoreboard;
		bit                 slot_valid [ENTRIES];
		logic [KEY_W-1:0]   slot_key   [ENTRIES];
		logic [VALUE_W-1:0] slot_value [ENTRIES];
		int unsigned        slot_rank  [ENTRIES];
		int unsigned        fill;
		logic [CAP_W-1:0]   capacity;
		rsp_t               pending_answers [$];
		int                 errors;

		function new();
			foreach (slot_valid[i]) slot_valid[i] = 1'b0;
			fill     = 0;
			capacity = CAP_RESET;
			errors   = 0;
		endfunction

		function void write_capacity(input logic [CAP_W-1:0] c);
			capacity = c;
		endfunction

		function int unsigned capacity_limit();
			if (capacity == 0) return 1;
			if (capacity > ENTRIES) return ENTRIES;
			return 32'(capacity);
		endfunction

		function int find_slot(input logic [KEY_W-1:0] k);
			for (int i = 0; i < ENTRIES; i++)
				if (slot_valid[i] && slot_key[i] == k) return i;
			return -1;
		endfunction

		function void promote(input int s);
			int unsigned r;
			r = slot_rank[s];
			for (int j = 0; j < ENTRIES; j++)
				if (slot_valid[j] && slot_rank[j] < r) slot_rank[j]++;
			slot_rank[s] = 0;
		endfunction

		function void insert(input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] v);
			int oldest;
			int free_slot;
			oldest    = -1;
			free_slot = -1;
			if (fill >= capacity_limit()) begin
				for (int j = 0; j < ENTRIES; j++)
					if (slot_valid[j] && (oldest < 0 || slot_rank[j] > slot_rank[oldest]))
						oldest = j;
				if (oldest >= 0) begin
					slot_valid[oldest] = 1'b0;
					fill--;
				end
			end
			for (int j = ENTRIES - 1; j >= 0; j--)
				if (!slot_valid[j]) free_slot = j;
			if (free_slot < 0) return;
			for (int j = 0; j < ENTRIES; j++)
				if (slot_valid[j]) slot_rank[j]++;
			slot_valid[free_slot] = 1'b1;
			slot_key[free_slot]   = k;
			slot_value[free_slot] = v;
			slot_rank[free_slot]  = 0;
			fill++;
		endfunction

		function void note_request(input req_t r);
			int s;
			rsp_t a;
			s = find_slot(r.key);
			if (r.command == CMD_GET) begin
				if (s >= 0) begin
					promote(s);
					a.hit        = 1'b1;
					a.read_value = slot_value[s];
				end else begin
					a.hit        = 1'b0;
					a.read_value = MISS_VALUE;
				end
				pending_answers.push_back(a);
			end else if (s >= 0) begin
				slot_value[s] = r.value;
				promote(s);
			end else begin
				insert(r.key, r.value);
			end
		endfunction

		function void check_result(input rsp_t got);
			rsp_t want;
			if (pending_answers.size() == 0) begin
				$error("unexpected result: hit %0b read_value %0d", got.hit, got.read_value);
				errors++;
				return;
			end
			want = pending_answers.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit mismatch: expected %0b, got %0b", want.hit, got.hit);
				errors++;
			end
			if (got.read_value !== want.read_value) begin
				$error("read_value mismatch: expected %0d, got %0d",
					want.read_value, got.read_value);
				errors++;
			end
		endfunction

		function int waiting();
			return pending_answers.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	req_t             in_data;
	logic             out_valid;
	logic             out_stall;
	rsp_t             out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	cache_scoreboard  sb;
	logic [KEY_W-1:0] key_pool [$];
	int               in_idle_pct;
	int               out_idle_pct;
	bit               hold_req;
	int               quiet_cycles;

	lru_key_value_cache #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(in_data);
			if (out_valid && !out_stall) sb.check_result(out_data);
			if (cfg_valid && cfg_ready) sb.write_capacity(cfg_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// result side stall pattern
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				if (hold_req) begin
					hold_req   = 1'b0;
					stall_left = HOLD_CYCLES;
				end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
					stall_left = $urandom_range(1, 4);
				end
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0) stall_left--;
		end
	end

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, key_pool.size() - 1)];
		return $urandom;
	endfunction

	task automatic new_pool(input int size);
		key_pool.delete();
		for (int i = 0; i < size; i++)
			key_pool.push_back($urandom_range(0, 7) == 0 ? random_value() : $urandom);
	endtask

	task automatic send_request(input cmd_t c, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		req_t r;
		r.command = c;
		r.key     = k;
		r.value   = v;
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic input_gap();
		if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.waiting() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int n);
		for (int i = 0; i < n; i++) begin
			send_request($urandom_range(0, 1) ? CMD_SET : CMD_GET, pick_key(), random_value());
			input_gap();
		end
	endtask

	initial begin
		logic [CAP_W-1:0] cap_plan [9];
		int               lim;
		sb           = new();
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		hold_req     = 1'b0;
		quiet_cycles = 0;
		in_idle_pct  = 0;
		out_idle_pct = 0;
		cap_plan     = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd1, 5'd17, 5'd8,
			5'($urandom_range(0, 31)), 5'($urandom_range(1, 16))};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty lookup, extreme keys and values, update in place
		send_request(CMD_GET, 32'h8000_0000, 32'h1234_5678);
		send_request(CMD_SET, 32'h8000_0000, 32'h7fff_ffff);
		send_request(CMD_SET, 32'h7fff_ffff, 32'h8000_0000);
		send_request(CMD_SET, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_SET, 32'hffff_ffff, 32'hffff_ffff);
		send_request(CMD_GET, 32'h8000_0000, 32'hffff_ffff);
		send_request(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
		send_request(CMD_GET, 32'h0000_0000, $urandom);
		send_request(CMD_GET, 32'hffff_ffff, $urandom);
		send_request(CMD_GET, 32'h0000_0001, $urandom);
		send_request(CMD_SET, 32'h0000_0000, 32'h1234_5678);
		send_request(CMD_GET, 32'h0000_0000, $urandom);
		send_request(CMD_GET, 32'hffff_fffe, $urandom);

		for (int p = 0; p < 9; p++) begin
			write_capacity(cap_plan[p]);
			lim = (cap_plan[p] == 0) ? 1 : (cap_plan[p] > ENTRIES) ? ENTRIES : 32'(cap_plan[p]);
			new_pool($urandom_range(1, 2 * lim + 3));
			in_idle_pct  = (p % 3 == 0) ? 0 : $urandom_range(5, 40);
			out_idle_pct = (p % 4 == 1) ? 0 : $urandom_range(5, 40);
			run_phase(PHASE_ITEMS);
			if (p == 4) begin
				// long receiver hold while gets keep coming
				hold_req    = 1'b1;
				in_idle_pct = 0;
				for (int i = 0; i < PRESSURE_ITEMS; i++)
					send_request(CMD_GET, pick_key(), $urandom);
			end
		end

		write_capacity(CAP_W'($urandom_range(0, 31)));
		new_pool($urandom_range(4, 20));
		in_idle_pct  = 0;
		out_idle_pct = 0;
		run_phase(PHASE_ITEMS);

		in_valid <= 1'b0;
		while (sb.waiting() != 0) @(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
